/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

   localparam int unsigned ByteW         = 8;
   localparam int unsigned SextetW       = 6;
   localparam int unsigned CharsPerGroup = 4;
   localparam int unsigned CharIdxW      = $clog2(CharsPerGroup);
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

   localparam logic [ByteW-1:0] PadChar = 8'h3D;

   // One encoded group of four characters; chars[0] goes out first.
   typedef struct packed {
      logic [CharsPerGroup-1:0][ByteW-1:0] chars;
      logic                                last;
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type group;
   } push_type;

   // Maps a 6-bit value onto the standard alphabet.
   function automatic logic [ByteW-1:0] sextet_char(input logic [SextetW-1:0] v);
      logic [ByteW-1:0] wide;
      wide = {2'b00, v};
      if (v < 6'd26) begin
         return wide + 8'd65;
      end else if (v < 6'd52) begin
         return wide + 8'd71;
      end else if (v < 6'd62) begin
         return wide - 8'd4;
      end else if (v == 6'd62) begin
         return 8'd43;
      end
      return 8'd47;
   endfunction

endpackage

/* hw/rtl/b64e_front.sv */
module b64e_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] data_byte
   input  logic                      req_tlast,   // last_byte
   input  logic                      q_full,
   output b64e_pkg::push_type        push
);
   import b64e_pkg::*;

   logic [1:0]             count_ff, count_in;
   logic [ByteW-1:0]       byte0_ff, byte0_in;
   logic [ByteW-1:0]       byte1_ff, byte1_in;
   logic                   accept;
   logic                   emit;
   logic [CharsPerGroup-1:0][SextetW-1:0] sx;
   logic [CharsPerGroup-1:0]              pad;

   assign req_tready = !q_full && !reset;
   assign accept     = req_tvalid && req_tready;
   // A count of three never occurs, but it is handled as two.
   assign emit       = count_ff[1] || req_tlast;

   always_comb begin
      sx  = '0;
      pad = '0;
      case (count_ff)
         2'd0: begin
            sx[0]  = req_tdata[7:2];
            sx[1]  = {req_tdata[1:0], 4'b0000};
            pad[2] = 1'b1;
            pad[3] = 1'b1;
         end
         2'd1: begin
            sx[0]  = byte0_ff[7:2];
            sx[1]  = {byte0_ff[1:0], req_tdata[7:4]};
            sx[2]  = {req_tdata[3:0], 2'b00};
            pad[3] = 1'b1;
         end
         default: begin
            sx[0] = byte0_ff[7:2];
            sx[1] = {byte0_ff[1:0], byte1_ff[7:4]};
            sx[2] = {byte1_ff[3:0], req_tdata[7:6]};
            sx[3] = req_tdata[5:0];
         end
      endcase
   end

   always_comb begin
      push.valid      = accept && emit;
      push.group.last = req_tlast;
      for (int i = 0; i < CharsPerGroup; i++) begin
         push.group.chars[i] = pad[i] ? PadChar : sextet_char(sx[i]);
      end
   end

   always_comb begin
      count_in = count_ff;
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      if (accept) begin
         if (emit) begin
            count_in = 2'd0;
         end else if (count_ff == 2'd0) begin
            count_in = 2'd1;
            byte0_in = req_tdata;
         end else begin
            count_in = 2'd2;
            byte1_in = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("pending byte count reached three");

   a_push_on_group: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == 2'd2) |=> count_ff == 2'd0)
      else $error("completed group did not clear the pending bytes");

endmodule

/* hw/rtl/b64e_queue.sv */
module b64e_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  b64e_pkg::push_type    push,
   output logic                  full,
   output logic                  q_valid,
   output b64e_pkg::group_type   q_group,
   input  logic                  q_pop
);
   import b64e_pkg::*;

   group_type              mem [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == QueueCntW'(QueueDepth));
   assign q_valid = (count_ff != '0);
   assign q_group = mem[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.group;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("group pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("queue count out of range");

endmodule

/* hw/rtl/b64e_back.sv */
module b64e_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  b64e_pkg::group_type   q_group,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_char
   output logic                  rsp_tlast    // out_last
);
   import b64e_pkg::*;

   localparam logic [CharIdxW-1:0] LastIdx = CharIdxW'(CharsPerGroup - 1);

   group_type             group_ff, group_in;
   logic [CharIdxW-1:0]   idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  xfer;

   assign xfer       = busy_ff && rsp_tready;
   // The next group loads in the same cycle as the last character's transfer.
   assign q_pop      = q_valid && (!busy_ff || (xfer && idx_ff == LastIdx));
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = group_ff.chars[idx_ff];
   assign rsp_tlast  = group_ff.last && (idx_ff == LastIdx);

   always_comb begin
      group_in = group_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (xfer) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LastIdx) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         group_in = q_group;
         idx_in   = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      group_ff <= group_in;
   end

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> idx_ff == '0)
      else $error("character index moved while idle");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (xfer && idx_ff != LastIdx) |=> busy_ff && idx_ff == $past(idx_ff) + 1'b1)
      else $error("character index did not advance after a transfer");

endmodule

/* hw/rtl/base64_encoder_top.sv */
// Path: a byte that completes or ends a group is written into the group queue and then
// loaded into the output serializer, which sends its four characters in order.
// Throughput: one character per cycle from the output serializer while the receiver is ready;
// a byte is taken every cycle while the two-group queue has room.
// Reset clears the pending byte count, the queue and the serializer; no clearing pass.
module base64_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast    // out_last
);
   import b64e_pkg::*;

   push_type    push;
   logic        q_full;
   logic        q_valid;
   group_type   q_group;
   logic        q_pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   b64e_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (q_full),
      .q_valid (q_valid),
      .q_group (q_group),
      .q_pop   (q_pop)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_group    (q_group),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/sv/tb_base64_encoder_top.sv */
module tb_base64_encoder_top;
   import b64e_pkg::*;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned HoldCycles  = 160;
   localparam int unsigned ByteCount   = 380;
   localparam int unsigned ReportLimit = 10;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             last;
   } msg_byte_type;

   typedef struct packed {
      logic [ByteW-1:0] code;
      logic             last;
   } enc_char_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ByteW-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic             req_tlast  = 1'b0; // last_byte
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [ByteW-1:0] rsp_tdata;         // [7:0] out_char
   logic             rsp_tlast;         // out_last

   msg_byte_type   bytes_to_send[$];
   enc_char_type   chars_due[$];
   logic [15:0] held_bytes = '0;
   logic [1:0]  held_count = '0;
   int unsigned mismatches = 0;
   int unsigned hold_left  = 0;

   base64_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [ByteW-1:0] alphabet(input logic [5:0] v);
      logic [ByteW-1:0] w;
      w = {2'b00, v};
      if (v < 6'd26) return "A" + w;
      if (v < 6'd52) return "a" + (w - 8'd26);
      if (v < 6'd62) return "0" + (w - 8'd52);
      if (v == 6'd62) return "+";
      return "/";
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none at all.
   function automatic int unsigned next_gap(inout int unsigned quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet != 0) begin
         quiet--;
         return 0;
      end
      if (roll < 4) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_byte(input logic [ByteW-1:0] data, input logic last);
      msg_byte_type item;
      item.data = data;
      item.last = last;
      bytes_to_send.push_back(item);
   endfunction

   function automatic void emit_char(input logic [ByteW-1:0] code, input logic last);
      enc_char_type c;
      c.code = code;
      c.last = last;
      chars_due.push_back(c);
   endfunction

   // Tracks the unfinished group and queues the characters that one byte releases.
   function automatic void encode_byte(input msg_byte_type item);
      logic [ByteW-1:0] b;
      logic [ByteW-1:0] b0;
      logic [ByteW-1:0] b1;
      b  = item.data;
      b0 = held_bytes[15:8];
      b1 = held_bytes[7:0];
      if (held_count >= 2'd2) begin
         emit_char(alphabet(b0[7:2]), 1'b0);
         emit_char(alphabet({b0[1:0], b1[7:4]}), 1'b0);
         emit_char(alphabet({b1[3:0], b[7:6]}), 1'b0);
         emit_char(alphabet(b[5:0]), item.last);
         held_bytes = '0;
         held_count = '0;
      end else if (held_count == 2'd0) begin
         if (item.last) begin
            emit_char(alphabet(b[7:2]), 1'b0);
            emit_char(alphabet({b[1:0], 4'b0000}), 1'b0);
            emit_char(PadChar, 1'b0);
            emit_char(PadChar, 1'b1);
         end else begin
            held_bytes = {b, 8'h00};
            held_count = 2'd1;
         end
      end else begin
         if (item.last) begin
            emit_char(alphabet(b0[7:2]), 1'b0);
            emit_char(alphabet({b0[1:0], b[7:4]}), 1'b0);
            emit_char(alphabet({b[3:0], 2'b00}), 1'b0);
            emit_char(PadChar, 1'b1);
            held_bytes = '0;
            held_count = '0;
         end else begin
            held_bytes = {b0, b};
            held_count = 2'd2;
         end
      end
   endfunction

   int unsigned send_gap   = 0;
   int unsigned send_quiet = 0;

   always @(posedge clock) begin
      msg_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            item = bytes_to_send.pop_front();
            req_tdata  <= item.data;
            req_tlast  <= item.last;
            req_tvalid <= 1'b1;
            send_gap = next_gap(send_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-offs while bytes keep coming, so the group queue fills up.
   int unsigned bytes_taken = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (req_tvalid && req_tready) bytes_taken++;
         if (req_tvalid && req_tready && (bytes_taken == 40 || bytes_taken == 220)) begin
            hold_left <= HoldCycles;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   int unsigned recv_stall = 0;
   int unsigned recv_quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall != 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_stall = next_gap(recv_quiet);
      end
   end

   // Prediction comes first so that an expectation is queued before any check at this edge.
   always @(posedge clock) begin
      enc_char_type due;
      msg_byte_type item;
      if (reset) begin
         held_bytes = '0;
         held_count = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            item.data = req_tdata;
            item.last = req_tlast;
            encode_byte(item);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (chars_due.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("unexpected character %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               due = chars_due.pop_front();
               if (rsp_tdata !== due.code || rsp_tlast !== due.last) begin
                  mismatches++;
                  if (mismatches <= ReportLimit)
                     $display("character mismatch: expected %h last %b, got %h last %b",
                              due.code, due.last, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   int unsigned cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned queued;
      int unsigned msg_len;
      int unsigned roll;
      logic [ByteW-1:0] b;

      // Single-byte messages at both extremes with two pad characters, then one with one pad.
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      // Full groups: all ones (all '/'), all zeros, and all '+'.
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hEF, 1'b0);
      queue_byte(8'hBE, 1'b1);
      // A group boundary crossed, ending with one and then two bytes left over.
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b0);
      queue_byte(8'h79, 1'b1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b0);
      queue_byte(8'h79, 1'b0);
      queue_byte(8'h2E, 1'b1);
      queued = bytes_to_send.size();

      while (queued < ByteCount) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) msg_len = 1;
         else if (roll < 85) msg_len = $urandom_range(2, 9);
         else msg_len = $urandom_range(10, 30);
         for (int unsigned i = 0; i < msg_len; i++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) b = 8'h00;
            else if (roll == 1) b = 8'hFF;
            else b = 8'($urandom_range(0, 255));
            queue_byte(b, i == msg_len - 1);
         end
         queued += msg_len;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (bytes_to_send.size() != 0 || req_tvalid || chars_due.size() != 0);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && chars_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
